FILE: hdl/gne_pkg.sv
package gne_pkg;

  // Coordinate and gradient formats.
  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int GRAD_W    = 16;
  localparam int GRAD_FRAC = GRAD_W - 2;
  localparam int OUT_FRAC  = 20;

  // Lattice table geometry.
  localparam int IDX_W     = 8;
  localparam int TBL_DEPTH = 1 << IDX_W;

  // Coordinates are shifted by this many lattice cells before splitting.
  localparam int COORD_OFFSET = 'h1000;
  localparam logic signed [COORD_W:0] T_OFFSET = (COORD_W + 1)'(COORD_OFFSET) << FRAC_BITS;

  // Internal datapath widths.
  localparam int R_W       = FRAC_BITS + 2;
  localparam int FADE_W    = FRAC_BITS + 4;
  localparam int KF_W      = FRAC_BITS + 3;
  localparam int PROD_W    = R_W + GRAD_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int DOT_SHIFT = FRAC_BITS + GRAD_FRAC - OUT_FRAC;
  localparam int DOT_W     = SUM_W - DOT_SHIFT;
  localparam int BLX_W     = DOT_W + 4;
  localparam int BLY_W     = BLX_W + 4;
  localparam int BLZ_W     = BLY_W + 4;

  localparam logic signed [R_W-1:0] R_ONE = R_W'(1) << FRAC_BITS;
  localparam logic signed [KF_W+0:0] K_THREE = (KF_W + 1)'(3) << FRAC_BITS;

  // Result format.
  localparam int OUT_W   = 23;
  localparam int OUT_MAX = 4194303;
  localparam int OUT_MIN = -4194304;

  // Command codes.
  localparam logic CMD_EVAL = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  // Dimension register codes.
  localparam int DIMS_W = 2;
  localparam logic [DIMS_W-1:0] DIMS_TWO   = 2'd2;
  localparam logic [DIMS_W-1:0] DIMS_THREE = 2'd3;
  localparam logic [DIMS_W-1:0] DIMS_RESET = DIMS_THREE;

  // Split of one coordinate: lattice cell pair and the two fractions.
  typedef struct packed {
    logic [IDX_W-1:0]       b0;
    logic [IDX_W-1:0]       b1;
    logic signed [R_W-1:0]  r0;
    logic signed [R_W-1:0]  r1;
  } axis_t;

  // Table load word as it travels down the pipeline.
  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [IDX_W-1:0]  perm;
    logic [GRAD_W-1:0] g1;
    logic [GRAD_W-1:0] g2x;
    logic [GRAD_W-1:0] g2y;
    logic [GRAD_W-1:0] g3x;
    logic [GRAD_W-1:0] g3y;
    logic [GRAD_W-1:0] g3z;
  } ld_t;

endpackage

FILE: hdl/gne_ram.sv
module gne_ram #(
  parameter int DW = 8
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic                       we,
  input  logic [gne_pkg::IDX_W-1:0]  waddr,
  input  logic [DW-1:0]              wdata,
  input  logic [gne_pkg::IDX_W-1:0]  raddr_a,
  input  logic [gne_pkg::IDX_W-1:0]  raddr_b,
  output logic [DW-1:0]              rdata_a,
  output logic [DW-1:0]              rdata_b
);
  import gne_pkg::*;

  logic [DW-1:0] mem [TBL_DEPTH];
  logic [DW-1:0] rd_a_r;
  logic [DW-1:0] rd_b_r;

  // Reads return the contents from before a write on the same edge.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[waddr] <= wdata;
      end
      rd_a_r <= mem[raddr_a];
      rd_b_r <= mem[raddr_b];
    end
  end

  assign rdata_a = rd_a_r;
  assign rdata_b = rd_b_r;

endmodule

FILE: hdl/gne_dly.sv
module gne_dly #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] pipe_r [N];

  always_ff @(posedge clk) begin
    if (en) begin
      pipe_r[0] <= d;
      for (int k = 1; k < N; k++) begin
        pipe_r[k] <= pipe_r[k-1];
      end
    end
  end

  assign q = pipe_r[N-1];

endmodule

FILE: hdl/gne_axis.sv
module gne_axis (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [gne_pkg::COORD_W-1:0] coord,
  output gne_pkg::axis_t                     ax,
  output logic signed [gne_pkg::FADE_W-1:0]  fade
);
  import gne_pkg::*;

  logic signed [COORD_W:0]    t_r, t_nxt;
  logic                       neg;
  logic [COORD_W:0]           mag;
  logic [IDX_W-1:0]           ipl;
  logic signed [R_W-1:0]      rpos;
  axis_t                      ax_r, ax_nxt;
  logic signed [2*R_W-1:0]    sq_prod;
  logic [FRAC_BITS-1:0]       sq_r, sq_nxt;
  logic signed [KF_W:0]       kf_full;
  logic [KF_W-1:0]            kf_r, kf_nxt;
  logic [FRAC_BITS+KF_W-1:0]  fade_prod;
  logic [KF_W-1:0]            fade_r, fade_nxt;

  // Offset coordinate.
  assign t_nxt = {coord[COORD_W-1], coord} + T_OFFSET;

  // Split by truncation toward zero: the fraction keeps the sign of t.
  always_comb begin
    neg  = t_r[COORD_W];
    mag  = neg ? (COORD_W + 1)'(-t_r) : t_r;
    ipl  = mag[FRAC_BITS +: IDX_W];
    rpos = {2'b00, mag[FRAC_BITS-1:0]};
    ax_nxt.b0 = neg ? (~ipl + 1'b1) : ipl;
    ax_nxt.b1 = ax_nxt.b0 + 1'b1;
    ax_nxt.r0 = neg ? -rpos : rpos;
    ax_nxt.r1 = ax_nxt.r0 - R_ONE;
  end

  // Fade curve t*t*(3-2t), squared term and linear term first.
  always_comb begin
    sq_prod = ax_r.r0 * ax_r.r0;
    sq_nxt  = sq_prod[2*FRAC_BITS-1:FRAC_BITS];
    kf_full = K_THREE - {ax_r.r0[R_W-1], ax_r.r0, 1'b0};
    kf_nxt  = kf_full[KF_W-1:0];
    fade_prod = sq_r * kf_r;
    fade_nxt  = fade_prod[FRAC_BITS +: KF_W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r    <= t_nxt;
      ax_r   <= ax_nxt;
      sq_r   <= sq_nxt;
      kf_r   <= kf_nxt;
      fade_r <= fade_nxt;
    end
  end

  assign ax   = ax_r;
  assign fade = {1'b0, fade_r};

endmodule

FILE: hdl/gne_blend.sv
module gne_blend #(
  parameter int W = 26
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [W-1:0]                lo,
  input  logic signed [W-1:0]                hi,
  input  logic signed [gne_pkg::FADE_W-1:0]  s,
  output logic signed [W+3:0]                res
);
  import gne_pkg::*;

  logic signed [W:0]            diff_r, diff_nxt;
  logic signed [W-1:0]          lo_r;
  logic signed [FADE_W-1:0]     s_r;
  logic signed [FADE_W+W:0]     prod;
  logic signed [W+3:0]          res_r, res_nxt;

  assign diff_nxt = {hi[W-1], hi} - {lo[W-1], lo};

  // lo + floor(s * (hi - lo) / one)
  always_comb begin
    prod    = s_r * diff_r;
    res_nxt = {{4{lo_r[W-1]}}, lo_r} + prod[FRAC_BITS +: W+4];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff_r <= diff_nxt;
      lo_r   <= lo;
      s_r    <= s;
      res_r  <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

FILE: hdl/gradient_noise_evaluator_core.sv
// Classic gradient noise in one, two or three dimensions on a fourteen-stage
// pipeline. One word is taken every clock cycle, load and evaluate words
// alike. An evaluate word gives its noise value from the last stage, and a
// load word gives nothing. The rate is set by the pipeline as a whole: a
// stall on the output freezes every stage, so the input stalls only while a
// finished result waits and the result side holds it off. A load writes one
// permutation entry and its gradients into one or more copies of each table,
// one copy per pair of lookups, and every copy is written in the stage that
// reads it, so words always see the tables in the order they were sent. The
// tables come up undefined and have no clearing pass; sample only after every
// entry the lattice can reach has been loaded. dimension_count is written
// through cfg_wr_en and cfg_wr_data; change it only while no evaluate word is
// in flight. A value of zero behaves as one dimension. Coordinates are signed
// Q15.16, gradients Q1.14, and the result is signed Q2.20, saturated.
module gradient_noise_evaluator_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_cmd,
  input  logic [gne_pkg::IDX_W-1:0]           in_table_index,
  input  logic [gne_pkg::IDX_W-1:0]           in_perm_entry,
  input  logic signed [gne_pkg::GRAD_W-1:0]   in_grad_one,
  input  logic signed [gne_pkg::GRAD_W-1:0]   in_grad_two_x,
  input  logic signed [gne_pkg::GRAD_W-1:0]   in_grad_two_y,
  input  logic signed [gne_pkg::GRAD_W-1:0]   in_grad_three_x,
  input  logic signed [gne_pkg::GRAD_W-1:0]   in_grad_three_y,
  input  logic signed [gne_pkg::GRAD_W-1:0]   in_grad_three_z,
  input  logic signed [gne_pkg::COORD_W-1:0]  in_coord_x,
  input  logic signed [gne_pkg::COORD_W-1:0]  in_coord_y,
  input  logic signed [gne_pkg::COORD_W-1:0]  in_coord_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [gne_pkg::OUT_W-1:0]    out_noise_value,
  input  logic                                cfg_wr_en,
  input  logic [gne_pkg::DIMS_W-1:0]          cfg_wr_data
);
  import gne_pkg::*;

  localparam int LAST_ST = 14;
  localparam int LD_ST   = 4;
  localparam int RR_W    = 6 * R_W;
  localparam logic signed [BLZ_W-1:0] SAT_HI = BLZ_W'(OUT_MAX);
  localparam logic signed [BLZ_W-1:0] SAT_LO = BLZ_W'(OUT_MIN);

  // Pipeline control. The whole pipeline advances together.
  logic                     adv;
  logic [LAST_ST:1]         ev_vld_r, ev_vld_nxt;
  logic [LD_ST:1]           ld_vld_r, ld_vld_nxt;
  logic [DIMS_W-1:0]        dims_r;
  ld_t                      ld_in;
  ld_t                      ld_r [1:LD_ST];

  // Coordinate split, stage 2, and fade values, stage 4.
  axis_t                    ax_x, ax_y, ax_z;
  logic signed [FADE_W-1:0] fx4, fy4, fz4;

  // Hash chain.
  logic [IDX_W-1:0]         i3, j3;
  logic [2*IDX_W-1:0]       yb3, zb4, ij4;
  logic [IDX_W-1:0]         h4 [4];

  // Gradient reads, stage 5.
  logic [GRAD_W-1:0]        g1_rd [2];
  logic [2*GRAD_W-1:0]      g2_rd [4];
  logic [3*GRAD_W-1:0]      g3_rd [8];
  logic [RR_W-1:0]          rr5;

  // Dot products.
  logic signed [PROD_W-1:0] prod_r [8][3];
  logic signed [PROD_W-1:0] prod_nxt [8][3];
  logic signed [DOT_W-1:0]  dot_r [8];
  logic signed [DOT_W-1:0]  dot_nxt [8];

  // Blend tree.
  logic [FADE_W-1:0]        fx7, fy9, fz11;
  logic signed [BLX_W-1:0]  bx [4];
  logic signed [BLY_W-1:0]  by [2];
  logic signed [BLZ_W-1:0]  bz;
  logic [BLX_W-1:0]         bx13;
  logic [BLY_W-1:0]         by13;
  logic signed [BLZ_W-1:0]  sel;
  logic signed [OUT_W-1:0]  noise_r, noise_nxt;

  assign adv       = !ev_vld_r[LAST_ST] || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = ev_vld_r[LAST_ST];
  assign out_noise_value = noise_r;

  // Loads and evaluates each carry their own valid bit down the pipeline.
  assign ev_vld_nxt = {ev_vld_r[LAST_ST-1:1], in_valid && (in_cmd == CMD_EVAL)};
  assign ld_vld_nxt = {ld_vld_r[LD_ST-1:1], in_valid && (in_cmd == CMD_LOAD)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_vld_r <= '0;
      ld_vld_r <= '0;
      dims_r   <= DIMS_RESET;
    end else begin
      if (cfg_wr_en) begin
        dims_r <= cfg_wr_data;
      end
      if (adv) begin
        ev_vld_r <= ev_vld_nxt;
        ld_vld_r <= ld_vld_nxt;
      end
    end
  end

  always_comb begin
    ld_in.idx  = in_table_index;
    ld_in.perm = in_perm_entry;
    ld_in.g1   = in_grad_one;
    ld_in.g2x  = in_grad_two_x;
    ld_in.g2y  = in_grad_two_y;
    ld_in.g3x  = in_grad_three_x;
    ld_in.g3y  = in_grad_three_y;
    ld_in.g3z  = in_grad_three_z;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ld_r[1] <= ld_in;
      for (int k = 2; k <= LD_ST; k++) begin
        ld_r[k] <= ld_r[k-1];
      end
    end
  end

  // Stages 1 to 4: offset, split into cell and fraction, then the fade curve.
  gne_axis u_axis_x (.clk(clk), .en(adv), .coord(in_coord_x), .ax(ax_x), .fade(fx4));
  gne_axis u_axis_y (.clk(clk), .en(adv), .coord(in_coord_y), .ax(ax_y), .fade(fy4));
  gne_axis u_axis_z (.clk(clk), .en(adv), .coord(in_coord_z), .ax(ax_z), .fade(fz4));

  // Stage 2 to 3: first permutation lookup on the two x cells.
  gne_ram #(.DW(IDX_W)) u_perm_x (
    .clk(clk), .en(adv), .we(ld_vld_r[2]), .waddr(ld_r[2].idx), .wdata(ld_r[2].perm),
    .raddr_a(ax_x.b0), .raddr_b(ax_x.b1), .rdata_a(i3), .rdata_b(j3)
  );

  gne_dly #(.W(2*IDX_W), .N(1)) u_dly_yb (
    .clk(clk), .en(adv), .d({ax_y.b1, ax_y.b0}), .q(yb3)
  );
  gne_dly #(.W(2*IDX_W), .N(2)) u_dly_zb (
    .clk(clk), .en(adv), .d({ax_z.b1, ax_z.b0}), .q(zb4)
  );
  gne_dly #(.W(2*IDX_W), .N(1)) u_dly_ij (
    .clk(clk), .en(adv), .d({j3, i3}), .q(ij4)
  );

  // Stage 3 to 4: second lookup gives the four x-y corner hashes, ordered
  // h00, h10, h01, h11. Table sums wrap at the table size.
  for (genvar k = 0; k < 2; k++) begin : g_perm_y
    gne_ram #(.DW(IDX_W)) u_perm_y (
      .clk(clk), .en(adv), .we(ld_vld_r[3]), .waddr(ld_r[3].idx), .wdata(ld_r[3].perm),
      .raddr_a(i3 + yb3[k*IDX_W +: IDX_W]), .raddr_b(j3 + yb3[k*IDX_W +: IDX_W]),
      .rdata_a(h4[2*k]), .rdata_b(h4[2*k+1])
    );
  end

  // Stage 4 to 5: gradient reads for every dimension count at once.
  gne_ram #(.DW(GRAD_W)) u_grad_one (
    .clk(clk), .en(adv), .we(ld_vld_r[LD_ST]), .waddr(ld_r[LD_ST].idx),
    .wdata(ld_r[LD_ST].g1),
    .raddr_a(ij4[IDX_W-1:0]), .raddr_b(ij4[2*IDX_W-1:IDX_W]),
    .rdata_a(g1_rd[0]), .rdata_b(g1_rd[1])
  );

  for (genvar k = 0; k < 2; k++) begin : g_grad_two
    gne_ram #(.DW(2*GRAD_W)) u_grad_two (
      .clk(clk), .en(adv), .we(ld_vld_r[LD_ST]), .waddr(ld_r[LD_ST].idx),
      .wdata({ld_r[LD_ST].g2y, ld_r[LD_ST].g2x}),
      .raddr_a(h4[2*k]), .raddr_b(h4[2*k+1]),
      .rdata_a(g2_rd[2*k]), .rdata_b(g2_rd[2*k+1])
    );
  end

  // Corners 0 to 3 sit on the lower z cell, 4 to 7 on the upper one.
  for (genvar k = 0; k < 4; k++) begin : g_grad_three
    localparam int CA = 2 * k;
    localparam int ZS = CA / 4;
    gne_ram #(.DW(3*GRAD_W)) u_grad_three (
      .clk(clk), .en(adv), .we(ld_vld_r[LD_ST]), .waddr(ld_r[LD_ST].idx),
      .wdata({ld_r[LD_ST].g3z, ld_r[LD_ST].g3y, ld_r[LD_ST].g3x}),
      .raddr_a(h4[CA % 4] + zb4[ZS*IDX_W +: IDX_W]),
      .raddr_b(h4[(CA + 1) % 4] + zb4[ZS*IDX_W +: IDX_W]),
      .rdata_a(g3_rd[CA]), .rdata_b(g3_rd[CA+1])
    );
  end

  gne_dly #(.W(RR_W), .N(3)) u_dly_rr (
    .clk(clk), .en(adv),
    .d({ax_z.r1, ax_z.r0, ax_y.r1, ax_y.r0, ax_x.r1, ax_x.r0}),
    .q(rr5)
  );

  // Stage 5 to 6: per-axis products for each of the eight corners. Corner
  // bit 0 picks the x fraction, bit 1 the y fraction, bit 2 the z fraction.
  // Unused axes and corners get a zero gradient.
  for (genvar c = 0; c < 8; c++) begin : g_corner
    localparam int BX = c % 2;
    localparam int BY = (c / 2) % 2;
    localparam int BZ = c / 4;
    logic signed [R_W-1:0]    rx, ry, rz;
    logic signed [GRAD_W-1:0] gx, gy, gz;
    logic signed [SUM_W-1:0]  sum;

    always_comb begin
      rx = $signed(rr5[(0 + BX)*R_W +: R_W]);
      ry = $signed(rr5[(2 + BY)*R_W +: R_W]);
      rz = $signed(rr5[(4 + BZ)*R_W +: R_W]);
      gx = '0;
      gy = '0;
      gz = '0;
      case (dims_r)
        DIMS_THREE: begin
          gx = $signed(g3_rd[c][0 +: GRAD_W]);
          gy = $signed(g3_rd[c][GRAD_W +: GRAD_W]);
          gz = $signed(g3_rd[c][2*GRAD_W +: GRAD_W]);
        end
        DIMS_TWO: begin
          if (c < 4) begin
            gx = $signed(g2_rd[c % 4][0 +: GRAD_W]);
            gy = $signed(g2_rd[c % 4][GRAD_W +: GRAD_W]);
          end
        end
        default: begin
          if (c < 2) begin
            gx = $signed(g1_rd[c % 2]);
          end
        end
      endcase
      prod_nxt[c][0] = rx * gx;
      prod_nxt[c][1] = ry * gy;
      prod_nxt[c][2] = rz * gz;
    end

    // Stage 6 to 7: sum and drop to 20 fraction bits by flooring.
    always_comb begin
      sum = {{2{prod_r[c][0][PROD_W-1]}}, prod_r[c][0]}
          + {{2{prod_r[c][1][PROD_W-1]}}, prod_r[c][1]}
          + {{2{prod_r[c][2][PROD_W-1]}}, prod_r[c][2]};
      dot_nxt[c] = sum[SUM_W-1:DOT_SHIFT];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        prod_r[c] <= prod_nxt[c];
        dot_r[c]  <= dot_nxt[c];
      end
    end
  end

  // Fade values wait for the blend levels that use them.
  gne_dly #(.W(FADE_W), .N(3)) u_dly_fx (.clk(clk), .en(adv), .d(fx4), .q(fx7));
  gne_dly #(.W(FADE_W), .N(5)) u_dly_fy (.clk(clk), .en(adv), .d(fy4), .q(fy9));
  gne_dly #(.W(FADE_W), .N(7)) u_dly_fz (.clk(clk), .en(adv), .d(fz4), .q(fz11));

  // Stages 7 to 13: blend along x, then y, then z, two stages per level.
  for (genvar k = 0; k < 4; k++) begin : g_blend_x
    gne_blend #(.W(DOT_W)) u_blend_x (
      .clk(clk), .en(adv), .lo(dot_r[2*k]), .hi(dot_r[2*k+1]),
      .s($signed(fx7)), .res(bx[k])
    );
  end

  for (genvar k = 0; k < 2; k++) begin : g_blend_y
    gne_blend #(.W(BLX_W)) u_blend_y (
      .clk(clk), .en(adv), .lo(bx[2*k]), .hi(bx[2*k+1]),
      .s($signed(fy9)), .res(by[k])
    );
  end

  gne_blend #(.W(BLY_W)) u_blend_z (
    .clk(clk), .en(adv), .lo(by[0]), .hi(by[1]), .s($signed(fz11)), .res(bz)
  );

  // The one- and two-dimensional results are held until the z level is done.
  gne_dly #(.W(BLX_W), .N(4)) u_dly_bx (.clk(clk), .en(adv), .d(bx[0]), .q(bx13));
  gne_dly #(.W(BLY_W), .N(2)) u_dly_by (.clk(clk), .en(adv), .d(by[0]), .q(by13));

  // Stage 13 to 14: pick the result for the dimension count and saturate.
  always_comb begin
    case (dims_r)
      DIMS_THREE: sel = bz;
      DIMS_TWO:   sel = {{(BLZ_W-BLY_W){by13[BLY_W-1]}}, by13};
      default:    sel = {{(BLZ_W-BLX_W){bx13[BLX_W-1]}}, bx13};
    endcase
    if (sel > SAT_HI) begin
      noise_nxt = SAT_HI[OUT_W-1:0];
    end else if (sel < SAT_LO) begin
      noise_nxt = SAT_LO[OUT_W-1:0];
    end else begin
      noise_nxt = sel[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      noise_r <= noise_nxt;
    end
  end

  // A pipeline slot never holds a load and an evaluate word at once.
  a_slot_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    (ev_vld_r[LD_ST:1] & ld_vld_r) == '0)
    else $error("load and evaluate words share a pipeline slot");

  // While the output holds off, nothing in the pipeline moves.
  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(ev_vld_r) && $stable(ld_vld_r))
    else $error("pipeline valid bits moved during a stall");

  // A load leaving the table stages leaves an empty slot behind it.
  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv && ld_vld_r[LD_ST] |=> !ev_vld_r[LD_ST+1])
    else $error("load word turned into a result");

endmodule
